// ===== design/mdpsk_pkg.sv =====
`default_nettype none
package mdpsk_pkg;
    localparam int SampleBits = 16;
    localparam int PhaseBits = 16;
    localparam int AccBits = 48;
    localparam int MaxSps = 1024;
    localparam int MaxBps = 6;
    localparam int CordicSteps = 16;
    localparam logic signed [17:0] RefStart = 18'sd19898;

    typedef enum logic [2:0] {
        CFG_SPS = 3'd0,
        CFG_STEP = 3'd1,
        CFG_START = 3'd2,
        CFG_OFFSET = 3'd3,
        CFG_BPS = 3'd4
    } t_cfg_idx;

    typedef struct packed {
        logic [10:0] sps;
        logic [15:0] step;
        logic [15:0] start;
        logic [15:0] offset;
        logic [2:0]  bps;
    } t_cfg;

    typedef struct packed {
        logic signed [AccBits-1:0] i_sum;
        logic signed [AccBits-1:0] q_sum;
    } t_qent;

    typedef enum logic [1:0] {F_IDLE, F_ROT, F_MUL, F_ACC} t_fstate;
    typedef enum logic [1:0] {B_IDLE, B_ROT, B_DONE} t_bstate;

    function automatic logic [31:0] atan_turn(input logic [3:0] i);
        logic [31:0] v;
        unique case (i)
            4'd0: v = 32'd536870912;
            4'd1: v = 32'd316933406;
            4'd2: v = 32'd167458907;
            4'd3: v = 32'd85004757;
            4'd4: v = 32'd42667331;
            4'd5: v = 32'd21354465;
            4'd6: v = 32'd10679838;
            4'd7: v = 32'd5340245;
            4'd8: v = 32'd2670163;
            4'd9: v = 32'd1335087;
            4'd10: v = 32'd667544;
            4'd11: v = 32'd333772;
            4'd12: v = 32'd166886;
            4'd13: v = 32'd83443;
            4'd14: v = 32'd41722;
            default: v = 32'd20861;
        endcase
        return v;
    endfunction
endpackage
`default_nettype wire

// ===== design/mdpsk_front.sv =====
`default_nettype none
module mdpsk_front import mdpsk_pkg::*; (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire t_cfg                  i_cfg,
    input  wire logic                  i_push,
    input  wire logic [SampleBits-1:0] i_sample,
    input  wire logic                  i_q_full,
    output logic                       o_full,
    output logic                       o_q_push,
    output t_qent                      o_q_data
);
    t_fstate r_state, n_state;
    logic [9:0] r_idx;
    logic [3:0] r_it;
    logic signed [SampleBits-1:0] r_smp;
    logic signed [17:0] r_x, r_y;
    logic signed [33:0] r_z;
    logic r_flip;
    logic signed [33:0] r_pi, r_pq;
    logic signed [AccBits-1:0] r_isum, r_qsum;

    logic [25:0] ph_prod;
    logic [15:0] ref_ph, fold_ph;
    logic fold;
    logic signed [17:0] dx, dy, cx, cy;
    logic signed [AccBits-1:0] ni, nq;
    logic [10:0] sps_c;
    logic sym_end;

    assign ph_prod = i_cfg.step * r_idx;
    assign ref_ph = i_cfg.start + ph_prod[15:0];
    assign fold = ref_ph[15] ^ ref_ph[14];
    assign fold_ph = fold ? (ref_ph ^ 16'h8000) : ref_ph;
    assign dx = r_y >>> r_it;
    assign dy = r_x >>> r_it;
    assign cx = r_flip ? -r_x : r_x;
    assign cy = r_flip ? -r_y : r_y;
    assign ni = r_isum + {{(AccBits-34){r_pi[33]}}, r_pi};
    assign nq = r_qsum + {{(AccBits-34){r_pq[33]}}, r_pq};
    assign sps_c = (i_cfg.sps < 11'd2) ? 11'd2 :
                   (i_cfg.sps > 11'(MaxSps)) ? 11'(MaxSps) : i_cfg.sps;
    assign sym_end = !({1'b0, r_idx} + 11'd1 < sps_c);
    assign o_full = (r_state != F_IDLE) || i_q_full;
    assign o_q_push = (r_state == F_ACC) && sym_end;
    assign o_q_data = '{i_sum: ni, q_sum: nq};

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            F_IDLE: if (i_push && !o_full) n_state = F_ROT;
            F_ROT: if (r_it == 4'(CordicSteps - 1)) n_state = F_MUL;
            F_MUL: n_state = F_ACC;
            F_ACC: n_state = F_IDLE;
            default: n_state = F_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
            r_idx <= '0;
            r_it <= '0;
            r_isum <= '0;
            r_qsum <= '0;
        end else begin
            r_state <= n_state;
            unique case (r_state)
                F_IDLE: begin
                    r_it <= '0;
                    if (i_push && !o_full) begin
                        r_smp <= i_sample;
                        r_flip <= fold;
                        r_x <= RefStart;
                        r_y <= '0;
                        r_z <= $signed({{2{fold_ph[15]}}, fold_ph, 16'h0000});
                    end
                end
                F_ROT: begin
                    r_it <= r_it + 4'd1;
                    if (r_z >= 0) begin
                        r_x <= r_x - dx;
                        r_y <= r_y + dy;
                        r_z <= r_z - $signed({2'b00, atan_turn(r_it)});
                    end else begin
                        r_x <= r_x + dx;
                        r_y <= r_y - dy;
                        r_z <= r_z + $signed({2'b00, atan_turn(r_it)});
                    end
                end
                F_MUL: begin
                    r_pi <= r_smp * cx;
                    r_pq <= r_smp * cy;
                end
                F_ACC: begin
                    if (sym_end) begin
                        r_idx <= '0;
                        r_isum <= '0;
                        r_qsum <= '0;
                    end else begin
                        r_idx <= r_idx + 10'd1;
                        r_isum <= ni;
                        r_qsum <= nq;
                    end
                end
                default: ;
            endcase
        end
    end
endmodule
`default_nettype wire

// ===== design/mdpsk_queue.sv =====
`default_nettype none
module mdpsk_queue import mdpsk_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_push,
    input  wire t_qent i_data,
    input  wire logic  i_pop,
    output logic       o_full,
    output logic       o_empty,
    output t_qent      o_data
);
    t_qent r_mem [2];
    logic r_wp, r_rp;
    logic [1:0] r_cnt;

    assign o_full = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_data = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push && !o_full) r_mem[r_wp] <= i_data;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= 1'b0;
            r_rp <= 1'b0;
            r_cnt <= '0;
        end else begin
            if (i_push && !o_full) r_wp <= !r_wp;
            if (i_pop && !o_empty) r_rp <= !r_rp;
            r_cnt <= r_cnt + 2'(i_push && !o_full) - 2'(i_pop && !o_empty);
        end
    end

    a_cnt_max: assert property (@(posedge i_clk) disable iff (!i_rst_n) r_cnt <= 2'd2)
        else $error("queue count overflow");
    a_no_over: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(i_push && o_full))
        else $error("push into full queue");
    a_no_under: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_pop && o_empty)) else $error("pop from empty queue");
endmodule
`default_nettype wire

// ===== design/mdpsk_back.sv =====
`default_nettype none
module mdpsk_back import mdpsk_pkg::*; (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire t_cfg                 i_cfg,
    input  wire logic                 i_q_empty,
    input  wire t_qent                i_q_data,
    output logic                      o_q_pop,
    input  wire logic                 i_pop,
    output logic                      o_empty,
    output logic [5:0]                o_symbol,
    output logic [PhaseBits-1:0]      o_phase_delta
);
    t_bstate r_state, n_state;
    logic signed [50:0] r_x, r_y;
    logic [31:0] r_z;
    logic [3:0] r_it;
    logic r_zero;
    logic r_have;
    logic [15:0] r_prev;
    logic r_ovalid;
    logic [5:0] r_sym;
    logic [15:0] r_diff;

    logic signed [50:0] ix, iy, dx, dy;
    logic [31:0] zr;
    logic [15:0] phase, diff, half, xs, kfull;
    logic [2:0] bps;
    logic [5:0] k, mask;
    logic can_out;

    assign ix = {{3{i_q_data.i_sum[AccBits-1]}}, i_q_data.i_sum};
    assign iy = {{3{i_q_data.q_sum[AccBits-1]}}, i_q_data.q_sum};
    assign dx = r_y >>> r_it;
    assign dy = r_x >>> r_it;
    assign zr = r_z + 32'h0000_8000;
    assign phase = r_zero ? 16'h0000 : zr[31:16];
    assign diff = phase - r_prev;
    assign bps = (i_cfg.bps < 3'd1) ? 3'd1 :
                 (i_cfg.bps > 3'(MaxBps)) ? 3'(MaxBps) : i_cfg.bps;
    assign half = (16'h0001 << (5'd16 - {2'b00, bps})) >> 1;
    assign xs = diff - i_cfg.offset - half;
    assign kfull = (xs >> (5'd16 - {2'b00, bps})) + 16'd1;
    assign mask = 6'((7'd1 << bps) - 7'd1);
    assign k = kfull[5:0] & mask;
    assign can_out = !r_ovalid || i_pop;
    assign o_q_pop = (r_state == B_IDLE) && !i_q_empty;
    assign o_empty = !r_ovalid;
    assign o_symbol = r_sym;
    assign o_phase_delta = r_diff;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            B_IDLE: if (!i_q_empty) n_state = B_ROT;
            B_ROT: if (r_it == 4'(CordicSteps - 1)) n_state = B_DONE;
            B_DONE: if (can_out) n_state = B_IDLE;
            default: n_state = B_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= B_IDLE;
            r_it <= '0;
            r_have <= 1'b0;
            r_prev <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == B_DONE && can_out && r_have) begin
                r_ovalid <= 1'b1;
            end else if (i_pop && r_ovalid) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                B_IDLE: begin
                    r_it <= '0;
                    if (!i_q_empty) begin
                        r_zero <= (ix == 0) && (iy == 0);
                        if (ix < 0) begin
                            r_x <= -ix;
                            r_y <= -iy;
                            r_z <= 32'h8000_0000;
                        end else begin
                            r_x <= ix;
                            r_y <= iy;
                            r_z <= '0;
                        end
                    end
                end
                B_ROT: begin
                    r_it <= r_it + 4'd1;
                    if (r_y >= 0) begin
                        r_x <= r_x + dx;
                        r_y <= r_y - dy;
                        r_z <= r_z + atan_turn(r_it);
                    end else begin
                        r_x <= r_x - dx;
                        r_y <= r_y + dy;
                        r_z <= r_z - atan_turn(r_it);
                    end
                end
                B_DONE: begin
                    if (can_out) begin
                        r_prev <= phase;
                        r_have <= 1'b1;
                        if (r_have) begin
                            r_sym <= k ^ (k >> 1);
                            r_diff <= diff;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && !i_pop) |=> (r_ovalid && $stable(r_sym) && $stable(r_diff)))
        else $error("result changed while waiting");
    a_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!r_have && !r_ovalid) |=> (!r_ovalid || r_have))
        else $error("result before first symbol");
    a_pop_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_q_pop |-> (r_state == B_IDLE)) else $error("queue pop while busy");
endmodule
`default_nettype wire

// ===== design/mdpsk_symbol_demodulator_core.sv =====
// channel   direction  transfer when          payload
// sample    in         push && !full          i_sample[15:0] signed
// result    out        pop && !empty          o_symbol[5:0], o_phase_delta[15:0]
// config    in         i_cfg_we               i_cfg_idx[2:0], i_cfg_data[15:0]
// a sample passes the front as one accept, 16 reference cordic steps, multiply and
// accumulate; the reference cordic loop sets the rate
// at the end of a symbol the back does one load, a 16-step vectoring cordic and a
// slicing step, in parallel with the front, through a two-entry sum queue
// full rises while the front works or the sum queue holds two symbols; a result waits in
// the output register until popped
// synchronous active-low reset clears control state and config to defaults
`default_nettype none
module mdpsk_symbol_demodulator_core import mdpsk_pkg::*; (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  push,
    output logic                       full,
    input  wire logic [SampleBits-1:0] i_sample,
    input  wire logic                  pop,
    output logic                       empty,
    output logic [5:0]                 o_symbol,
    output logic [PhaseBits-1:0]       o_phase_delta,
    input  wire logic                  i_cfg_we,
    input  wire logic [2:0]            i_cfg_idx,
    input  wire logic [15:0]           i_cfg_data
);
    t_cfg r_cfg;
    logic q_push, q_pop, q_full, q_empty;
    t_qent q_in, q_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '{sps: 11'd16, step: 16'd4096, start: 16'd0, offset: 16'd0, bps: 3'd1};
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_SPS: r_cfg.sps <= i_cfg_data[10:0];
                CFG_STEP: r_cfg.step <= i_cfg_data;
                CFG_START: r_cfg.start <= i_cfg_data;
                CFG_OFFSET: r_cfg.offset <= i_cfg_data;
                CFG_BPS: r_cfg.bps <= i_cfg_data[2:0];
                default: ;
            endcase
        end
    end

    mdpsk_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg(r_cfg),
        .i_push(push), .i_sample(i_sample), .i_q_full(q_full),
        .o_full(full), .o_q_push(q_push), .o_q_data(q_in)
    );

    mdpsk_queue u_queue (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(q_push), .i_data(q_in),
        .i_pop(q_pop), .o_full(q_full), .o_empty(q_empty), .o_data(q_out)
    );

    mdpsk_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg(r_cfg),
        .i_q_empty(q_empty), .i_q_data(q_out), .o_q_pop(q_pop),
        .i_pop(pop), .o_empty(empty), .o_symbol(o_symbol),
        .o_phase_delta(o_phase_delta)
    );
endmodule
`default_nettype wire

// ===== verif/tb_top.sv =====
`timescale 1ns / 100ps
module tb_top;
    import mdpsk_pkg::*;

    localparam int CycleLimit = 1000000;
    localparam int Settle = 60;
    localparam real TwoPi = 6.283185307179586;

    typedef struct {
        logic [5:0]  sym;
        logic [15:0] pdelta;
    } t_symbol_result;

    class symbol_scoreboard;
        t_cfg cfg;
        logic [9:0] sample_idx;
        logic [47:0] i_acc;
        logic [47:0] q_acc;
        logic [15:0] last_phase;
        bit have_last;
        t_symbol_result pending_q[$];
        int errors;

        function new();
            cfg = '{sps: 11'd16, step: 16'd4096, start: 16'd0, offset: 16'd0, bps: 3'd1};
            sample_idx = '0;
            i_acc = '0;
            q_acc = '0;
            last_phase = '0;
            have_last = 0;
            errors = 0;
        endfunction

        function void write_reg(t_cfg_idx r, logic [15:0] d);
            case (r)
                CFG_SPS: cfg.sps = d[10:0];
                CFG_STEP: cfg.step = d;
                CFG_START: cfg.start = d;
                CFG_OFFSET: cfg.offset = d;
                CFG_BPS: cfg.bps = d[2:0];
                default: ;
            endcase
        endfunction

        function logic [31:0] atan_lut(int i);
            logic [31:0] t [16];
            t = '{32'd536870912, 32'd316933406, 32'd167458907, 32'd85004757,
                  32'd42667331, 32'd21354465, 32'd10679838, 32'd5340245,
                  32'd2670163, 32'd1335087, 32'd667544, 32'd333772,
                  32'd166886, 32'd83443, 32'd41722, 32'd20861};
            return t[i];
        endfunction

        function void rotate_ref(logic [15:0] ph, output longint c, output longint s);
            logic [31:0] a;
            bit flip;
            longint x, y, z, dx, dy;
            a = {ph, 16'h0};
            flip = 0;
            if (a >= 32'h4000_0000 && a < 32'hC000_0000) begin
                a = a - 32'h8000_0000;
                flip = 1;
            end
            z = longint'($signed(a));
            x = 19898;
            y = 0;
            for (int i = 0; i < CordicSteps; i++) begin
                dx = y >>> i;
                dy = x >>> i;
                if (z >= 0) begin
                    x -= dx; y += dy; z -= longint'(atan_lut(i));
                end else begin
                    x += dx; y -= dy; z += longint'(atan_lut(i));
                end
            end
            c = flip ? -x : x;
            s = flip ? -y : y;
        endfunction

        function logic [15:0] vector_angle(longint x, longint y);
            logic [31:0] z;
            longint dx, dy;
            z = '0;
            if (x == 0 && y == 0) return 16'd0;
            if (x < 0) begin
                x = -x; y = -y; z = 32'h8000_0000;
            end
            for (int i = 0; i < CordicSteps; i++) begin
                dx = y >>> i;
                dy = x >>> i;
                if (y >= 0) begin
                    x += dx; y -= dy; z += atan_lut(i);
                end else begin
                    x -= dx; y += dy; z -= atan_lut(i);
                end
            end
            z = z + 32'h8000;
            return z[31:16];
        endfunction

        function void note_sample(logic [15:0] smp);
            longint s, c, sn;
            logic [15:0] rp, ph, diff, half, x, k, mask;
            int sps, bits;
            t_symbol_result r;
            s = longint'($signed(smp));
            rp = cfg.start + cfg.step * {6'd0, sample_idx};
            rotate_ref(rp, c, sn);
            i_acc = i_acc + 48'(s * c);
            q_acc = q_acc + 48'(s * sn);
            sps = cfg.sps;
            if (sps < 2) sps = 2;
            if (sps > MaxSps) sps = MaxSps;
            if (int'(sample_idx) + 1 < sps) begin
                sample_idx++;
                return;
            end
            ph = vector_angle(longint'($signed(i_acc)), longint'($signed(q_acc)));
            sample_idx = '0;
            i_acc = '0;
            q_acc = '0;
            diff = ph - last_phase;
            last_phase = ph;
            if (!have_last) begin
                have_last = 1;
                return;
            end
            bits = cfg.bps;
            if (bits < 1) bits = 1;
            if (bits > MaxBps) bits = MaxBps;
            half = (16'd1 << (16 - bits)) >> 1;
            x = diff - cfg.offset - half;
            mask = (16'd1 << bits) - 16'd1;
            k = ((x >> (16 - bits)) + 16'd1) & mask;
            r.sym = 6'(k ^ (k >> 1));
            r.pdelta = diff;
            pending_q.push_back(r);
        endfunction

        function void check_result(logic [5:0] sym, logic [15:0] pdelta);
            t_symbol_result e;
            if (pending_q.size() == 0) begin
                $error("unexpected result symbol=%0d phase_delta=%0d", sym, pdelta);
                errors++;
                return;
            end
            e = pending_q.pop_front();
            if (sym !== e.sym) begin
                $error("symbol expected %0d actual %0d", e.sym, sym);
                errors++;
            end
            if (pdelta !== e.pdelta) begin
                $error("phase_delta expected %0d actual %0d", e.pdelta, pdelta);
                errors++;
            end
        endfunction
    endclass

    logic i_clk = 0;
    logic i_rst_n = 0;
    logic push = 0;
    logic full;
    logic [15:0] i_sample = '0;
    logic pop = 0;
    logic empty;
    logic [5:0] o_symbol;
    logic [15:0] o_phase_delta;
    logic i_cfg_we = 0;
    logic [2:0] i_cfg_idx = '0;
    logic [15:0] i_cfg_data = '0;

    symbol_scoreboard sb = new();
    int cycles = 0;
    bit hold_req = 0;
    int eff_sps = 16;

    mdpsk_symbol_demodulator_core DUT (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .push(push),
        .full(full),
        .i_sample(i_sample),
        .pop(pop),
        .empty(empty),
        .o_symbol(o_symbol),
        .o_phase_delta(o_phase_delta),
        .i_cfg_we(i_cfg_we),
        .i_cfg_idx(i_cfg_idx),
        .i_cfg_data(i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CycleLimit) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    task automatic send_sample(logic [15:0] smp);
        int gap;
        gap = $urandom_range(0, 10);
        if ($urandom_range(0, 3) == 0) gap = 0;
        if (gap > 0) begin
            push <= 0;
            repeat (gap) @(posedge i_clk);
        end
        push <= 1;
        i_sample <= smp;
        do @(posedge i_clk); while (full);
        sb.note_sample(smp);
    endtask

    task automatic drain();
        push <= 0;
        while (sb.pending_q.size() != 0) @(posedge i_clk);
        repeat (Settle) @(posedge i_clk);
    endtask

    task automatic set_cfg(int sps, int step, int start, int offset, int bps);
        logic [15:0] d [5];
        d[0] = {5'($urandom), 11'(sps)};
        d[1] = 16'(step);
        d[2] = 16'(start);
        d[3] = 16'(offset);
        d[4] = {13'($urandom), 3'(bps)};
        for (int r = 0; r < 5; r++) begin
            i_cfg_we <= 1;
            i_cfg_idx <= 3'(r);
            i_cfg_data <= d[r];
            @(posedge i_clk);
            sb.write_reg(t_cfg_idx'(r), d[r]);
        end
        i_cfg_we <= 0;
        @(posedge i_clk);
        eff_sps = sps < 2 ? 2 : (sps > MaxSps ? MaxSps : sps);
    endtask

    // one symbol of a tone at the reference rate, rotated by phi
    task automatic send_tone(real phi, int amp);
        real th, v;
        for (int k = 0; k < eff_sps; k++) begin
            th = TwoPi * real'((sb.cfg.start + sb.cfg.step * k) % 65536) / 65536.0;
            v = real'(amp) * $cos(th + phi) + real'($urandom_range(0, 200)) - 100.0;
            if (v > 32767.0) v = 32767.0;
            if (v < -32768.0) v = -32768.0;
            send_sample(16'($rtoi(v)));
        end
    endtask

    task automatic run_phase(int n_items);
        int sent, m, n;
        real phi;
        phi = 0.0;
        sent = 0;
        m = 1 << ((sb.cfg.bps < 1) ? 1 : (sb.cfg.bps > MaxBps ? MaxBps : sb.cfg.bps));
        while (sent < n_items) begin
            if ($urandom_range(0, 3) != 0) begin
                phi = phi + TwoPi * real'($urandom_range(0, m - 1)) / real'(m)
                      + real'($urandom_range(0, 100)) / 1000.0;
                send_tone(phi, $urandom_range(50, 32767));
                sent += eff_sps;
            end else begin
                n = $urandom_range(1, eff_sps);
                for (int k = 0; k < n; k++) send_sample(16'($urandom));
                sent += n;
            end
        end
    endtask

    always begin
        int stall;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            stall = $urandom_range(0, 10);
            if ($urandom_range(0, 3) == 0) stall = 0;
            if (hold_req) begin
                stall = 3000;
                hold_req = 0;
            end
            if (stall > 0) begin
                pop <= 0;
                repeat (stall) @(posedge i_clk);
            end
            pop <= 1;
            do @(posedge i_clk); while (empty);
            sb.check_result(o_symbol, o_phase_delta);
        end
    end

    initial begin
        logic [15:0] edge_vals [12];
        edge_vals = '{16'h7FFF, 16'h8000, 16'h0000, 16'h0000, 16'h8000, 16'h7FFF,
                      16'h0001, 16'hFFFF, 16'h5555, 16'hAAAA, 16'h7FFF, 16'h7FFF};
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        for (int k = 0; k < 32; k++) send_sample(16'($urandom));
        drain();

        set_cfg(2, 0, 0, 0, 6);
        foreach (edge_vals[k]) send_sample(edge_vals[k]);
        drain();
        set_cfg(0, 65535, 65535, 65535, 0);
        for (int k = 0; k < 6; k++) send_sample(edge_vals[k]);
        drain();
        set_cfg(1, 16384, 32768, 32768, 7);
        for (int k = 0; k < 6; k++) send_sample(edge_vals[k + 6]);
        drain();

        for (int p = 0; p < 8; p++) begin
            case (p)
                0: set_cfg(2, 0, 0, 0, 1);
                1: set_cfg(4, 65535, 65535, 65535, 6);
                2: set_cfg(3, 8192, 0, 65535, 2);
                3: set_cfg(8, 4096, 12345, 0, 3);
                default: set_cfg($urandom_range(0, 12), $urandom, $urandom, $urandom,
                                 $urandom_range(0, 7));
            endcase
            if (p == 5) begin
                set_cfg(2, $urandom, $urandom, $urandom, 4);
                hold_req = 1;
            end
            run_phase(20);
            drain();
        end

        // lowering the symbol length mid-symbol
        set_cfg(8, 4096, 0, 0, 2);
        for (int k = 0; k < 5; k++) send_sample(16'($urandom));
        drain();
        set_cfg(2, 4096, 0, 0, 2);
        for (int k = 0; k < 5; k++) send_sample(16'($urandom));
        drain();

        // symbol length above the maximum, one full clamped symbol
        set_cfg(2047, 64, 0, 0, 3);
        send_tone(0.5, 20000);
        drain();

        if (sb.errors == 0 && sb.pending_q.size() == 0) begin
            $display("TB_OK");
        end else begin
            if (sb.pending_q.size() != 0)
                $error("%0d results never arrived", sb.pending_q.size());
            $display("TB_ERROR");
        end
        $finish;
    end
endmodule
